[sv/bdap_pkg.sv]
// Package for the blank-padded binary to decimal ASCII converter.
// Holds the digit count, character codes and the power-of-ten weight table.
// No dependencies.
package bdap_pkg;

	localparam int unsigned DIGITS = 10;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned REM_W  = 32;
	localparam int unsigned WGT_W  = 33;
	localparam int unsigned CHAR_W = 6;

	localparam logic [POS_W-1:0]  POS_FIRST = 4'd0;
	localparam logic [POS_W-1:0]  POS_UNITS = 4'(DIGITS - 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

	typedef logic [REM_W-1:0] rem_t;
	typedef logic [WGT_W-1:0] wgt_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CHAR_W-1:0] char_t;

	// Power of ten for each digit position, most significant first.
	function automatic wgt_t pow10(input pos_t pos);
		wgt_t p;
		unique case (pos)
			4'd0:    p = 33'd1000000000;
			4'd1:    p = 33'd100000000;
			4'd2:    p = 33'd10000000;
			4'd3:    p = 33'd1000000;
			4'd4:    p = 33'd100000;
			4'd5:    p = 33'd10000;
			4'd6:    p = 33'd1000;
			4'd7:    p = 33'd100;
			4'd8:    p = 33'd10;
			4'd9:    p = 33'd1;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

[sv/binary_to_decimal_ascii_padded.sv]
// Blank-padded binary to decimal ASCII converter, top level.
// Depends on bdap_pkg.
//
// Usage:
//  - Command channel: value is taken at a rising edge with start high and busy
//    low. One item may wait in the input register while the previous one is
//    still being printed; busy is high while that register is occupied.
//  - Result channel: ten characters per item, most significant digit first,
//    each on character for one cycle with strobe high. last marks the units
//    digit. Leading zeros come out as spaces; the units digit is always a digit.
//  - Timing: an accepted value moves from the input register to the working
//    registers and then to the result register, which drives strobe. One
//    character is produced per cycle while an item is being printed, with
//    characters of consecutive items back to back when the next one waits.
//  - Each cycle finds one digit by four compare-and-subtract steps against
//    8, 4, 2 and 1 times that position's power of ten.
//  - Reset clears the input and working valid flags and the strobe; any item
//    in flight is dropped. The receiver cannot stall the result channel.
module binary_to_decimal_ascii_padded (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 value,
	output logic                        strobe,
	output logic [5:0]                  character,
	output logic                        last
);

	bdap_pkg::rem_t  value_s1;
	logic            valid_s1;

	bdap_pkg::rem_t  rem_q;
	bdap_pkg::pos_t  pos_q;
	logic            leading_q;
	logic            active_q;

	bdap_pkg::char_t character_q;
	logic            last_q;
	logic            strobe_q;

	logic            in_xfer;
	logic            load;
	logic            finishing;

	bdap_pkg::wgt_t  p10;
	bdap_pkg::wgt_t  r0, r1, r2, r3, r4;
	bdap_pkg::wgt_t  w8, w4, w2, w1;
	logic [3:0]      digit;
	logic            shown;
	bdap_pkg::char_t char_d;

	assign busy      = valid_s1;
	assign in_xfer   = start && !busy;
	assign finishing = active_q && (pos_q == bdap_pkg::POS_UNITS);
	assign load      = valid_s1 && (!active_q || finishing);

	always_comb begin
		p10 = bdap_pkg::pow10(pos_q);
		w8  = p10 << 3;
		w4  = p10 << 2;
		w2  = p10 << 1;
		w1  = p10;
		r0  = {1'b0, rem_q};
		digit = '0;
		if (r0 >= w8) begin
			r1 = r0 - w8;
			digit[3] = 1'b1;
		end else begin
			r1 = r0;
		end
		if (r1 >= w4) begin
			r2 = r1 - w4;
			digit[2] = 1'b1;
		end else begin
			r2 = r1;
		end
		if (r2 >= w2) begin
			r3 = r2 - w2;
			digit[1] = 1'b1;
		end else begin
			r3 = r2;
		end
		if (r3 >= w1) begin
			r4 = r3 - w1;
			digit[0] = 1'b1;
		end else begin
			r4 = r3;
		end
		shown  = (digit != 4'd0) || !leading_q || (pos_q == bdap_pkg::POS_UNITS);
		char_d = shown ? (bdap_pkg::CHAR_ZERO + bdap_pkg::char_t'(digit))
			: bdap_pkg::CHAR_SPACE;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_s1 <= value;
		end
	end

	// working remainder and digit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pos_q     <= bdap_pkg::POS_FIRST;
			leading_q <= 1'b1;
		end else if (load) begin
			active_q  <= 1'b1;
			pos_q     <= bdap_pkg::POS_FIRST;
			leading_q <= 1'b1;
		end else if (finishing) begin
			active_q  <= 1'b0;
		end else if (active_q) begin
			pos_q     <= pos_q + 4'd1;
			leading_q <= leading_q && !shown;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= value_s1;
		end else if (active_q) begin
			rem_q <= r4[bdap_pkg::REM_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			character_q <= char_d;
			last_q      <= (pos_q == bdap_pkg::POS_UNITS);
		end
	end

	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q && strobe_q;

	// position advances by one each cycle of a conversion
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && (pos_q != bdap_pkg::POS_UNITS) |=>
			active_q && (pos_q == $past(pos_q) + 4'd1))
		else $error("digit position did not advance");

	// once a digit has been printed, no further blanking within the item
	a_no_blank_after_digit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last && (character != bdap_pkg::CHAR_SPACE) |=>
			strobe && (character != bdap_pkg::CHAR_SPACE))
		else $error("space after a printed digit");

	// the units character is always a digit
	a_units_digit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> (character >= bdap_pkg::CHAR_ZERO) &&
			(character <= bdap_pkg::CHAR_ZERO + 6'd9))
		else $error("units character is not a digit");

	// a waiting item enters the converter as soon as the current one finishes
	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		finishing && valid_s1 |=> active_q && (pos_q == bdap_pkg::POS_FIRST))
		else $error("queued item not taken at end of conversion");

endmodule

[tb/binary_to_decimal_ascii_padded_tb.sv]
`timescale 1ns / 100ps
// Testbench for binary_to_decimal_ascii_padded: ten-character decimal printing.
// Each value is checked character by character, with bursty command traffic.
// Depends on bdap_pkg and binary_to_decimal_ascii_padded.
module binary_to_decimal_ascii_padded_tb;

	typedef longint unsigned u64_t;

	typedef struct packed {
		bdap_pkg::char_t code;
		logic            last;
	} glyph_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value;
	logic        strobe;
	logic [5:0]  character;
	logic        last;

	glyph_t      pending_glyphs[$];
	int unsigned mismatches;
	int unsigned values_sent;
	int unsigned glyphs_checked;
	int unsigned burst_left;

	binary_to_decimal_ascii_padded dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("binary_to_decimal_ascii_padded: mismatch");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Right-aligned decimal, blanks for leading zeros, units always a digit.
	function automatic void predict_glyphs(input logic [31:0] v);
		logic [3:0]  digit [bdap_pkg::DIGITS];
		logic [31:0] rest;
		logic        blank;
		glyph_t      g;
		rest = v;
		for (int i = int'(bdap_pkg::DIGITS) - 1; i >= 0; i--) begin
			digit[i] = 4'(rest % 10);
			rest = rest / 10;
		end
		blank = 1'b1;
		for (int i = 0; i < int'(bdap_pkg::DIGITS); i++) begin
			if (digit[i] != 4'd0 || i == int'(bdap_pkg::DIGITS) - 1)
				blank = 1'b0;
			g.code = blank ? bdap_pkg::CHAR_SPACE
				: bdap_pkg::CHAR_ZERO + bdap_pkg::char_t'(digit[i]);
			g.last = (i == int'(bdap_pkg::DIGITS) - 1);
			pending_glyphs.push_back(g);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe !== 1'b0) begin
			if (pending_glyphs.size() == 0) begin
				flag_mismatch($sformatf("unexpected character %0d last %b", character, last));
			end else begin
				if (character !== pending_glyphs[0].code)
					flag_mismatch($sformatf("character %0d, expected %0d",
						character, pending_glyphs[0].code));
				if (last !== pending_glyphs[0].last)
					flag_mismatch($sformatf("last %b, expected %b",
						last, pending_glyphs[0].last));
				void'(pending_glyphs.pop_front());
				glyphs_checked++;
			end
		end
	end

	// One command transfer; bursts of random length separated by random gaps.
	task automatic send_value(input logic [31:0] v);
		int unsigned idle_cycles;
		if (burst_left == 0) begin
			idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (idle_cycles != 0) begin
				start <= 1'b0;
				repeat (idle_cycles) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		predict_glyphs(v);
		burst_left--;
		values_sent++;
	endtask

	task automatic test_directed();
		logic [31:0] corner [] = '{
			32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd65535, 32'd65536,
			32'd65537, 32'd99999, 32'd100000, 32'd999999999, 32'd1000000000,
			32'd1000000001, 32'd2147483647, 32'd2147483648, 32'd3999999999,
			32'd4000000000, 32'd4294967294, 32'd4294967295, 32'h5555_5555,
			32'hAAAA_AAAA, 32'd1010101010, 32'd7
		};
		foreach (corner[i])
			send_value(corner[i]);
	endtask

	task automatic test_digit_widths(input int unsigned count);
		u64_t        lo;
		u64_t        hi;
		u64_t        r;
		int unsigned width;
		repeat (count) begin
			width = $urandom_range(1, bdap_pkg::DIGITS);
			lo = 1;
			repeat (width - 1) lo = lo * 10;
			hi = lo * 10 - 1;
			if (hi > 64'hFFFF_FFFF)
				hi = 64'hFFFF_FFFF;
			if (width == 1)
				lo = 0;
			r = $urandom;
			send_value(32'(lo + r % (hi - lo + 1)));
		end
	endtask

	// Many zero digits inside the number.
	task automatic test_sparse_digits(input int unsigned count);
		u64_t acc;
		repeat (count) begin
			acc = 0;
			for (int i = 0; i < int'(bdap_pkg::DIGITS); i++) begin
				acc = acc * 10;
				if ($urandom_range(0, 1) != 0)
					acc = acc + $urandom_range(1, 9);
			end
			while (acc > 64'hFFFF_FFFF)
				acc = acc - 64'd1000000000;
			send_value(32'(acc));
		end
	endtask

	task automatic test_full_range(input int unsigned count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send_value(32'hFFFF_FFFF - $urandom_range(0, 1000));
			else
				send_value($urandom);
		end
	endtask

	task automatic drain_results();
		int unsigned guard;
		start <= 1'b0;
		guard = 0;
		while (pending_glyphs.size() != 0 && guard < 100_000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_glyphs.size() != 0)
			flag_mismatch($sformatf("%0d characters never arrived", pending_glyphs.size()));
		repeat (16) @(posedge clk);
	endtask

	initial begin
		mismatches     = 0;
		values_sent    = 0;
		glyphs_checked = 0;
		burst_left     = 0;
		clk            = 1'b0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_digit_widths(80);
		test_sparse_digits(60);
		test_full_range(60);
		drain_results();

		$display("Printed %0d values (corners, every digit width, sparse and full-range)",
			values_sent);
		$display("Compared %0d characters", glyphs_checked);
		if (mismatches == 0)
			$display("binary_to_decimal_ascii_padded: match");
		else
			$display("binary_to_decimal_ascii_padded: mismatch");
		$finish;
	end

endmodule
